FILE: rtl/hhpm_pkg.sv
// shared types and constants for the http host pattern matcher
`default_nettype none
package hhpm_pkg;
    typedef enum logic [1:0] {
        PH_SEARCH  = 2'd0,
        PH_SKIP    = 2'd1,
        PH_CAPTURE = 2'd2,
        PH_DONE    = 2'd3
    } t_host_phase;

    localparam logic [2:0] REG_PAT0 = 3'd0;
    localparam logic [2:0] REG_PAT1 = 3'd1;
    localparam logic [2:0] REG_PAT2 = 3'd2;
    localparam logic [2:0] REG_PAT3 = 3'd3;
    localparam logic [2:0] REG_PLEN = 3'd4;

    localparam logic [15:0] HTTP_PORT = 16'd80;
    localparam logic [7:0]  CH_NUL    = 8'h00;
    localparam logic [7:0]  CH_CR     = 8'h0d;
    localparam logic [7:0]  CH_SPACE  = 8'h20;

    typedef struct packed {
        logic [7:0] payload_byte;
        logic       byte_valid;
        logic       first_of_packet;
        logic       last_of_packet;
        logic       eligible;
    } t_item;
endpackage
`default_nettype wire

FILE: rtl/hhpm_front.sv
// input stage: samples packet eligibility and feeds a two-entry item queue
`default_nettype none
module hhpm_front
    import hhpm_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic [7:0]  i_payload_byte,
    input  wire logic        i_byte_valid,
    input  wire logic        i_first_of_packet,
    input  wire logic        i_last_of_packet,
    input  wire logic [15:0] i_dest_port,
    input  wire logic        i_is_tcp,
    output logic             o_valid,
    input  wire logic        i_ready,
    output t_item            o_item
);
    t_item      r_q [2];
    logic       r_rd, n_rd;
    logic       r_wr, n_wr;
    logic [1:0] r_cnt, n_cnt;
    logic       push, pop;
    t_item      w_item;

    assign o_ready = (r_cnt != 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_item  = r_q[r_rd];
    assign push    = i_valid && o_ready;
    assign pop     = o_valid && i_ready;

    always_comb begin
        w_item.payload_byte    = i_payload_byte;
        w_item.byte_valid      = i_byte_valid;
        w_item.first_of_packet = i_first_of_packet;
        w_item.last_of_packet  = i_last_of_packet;
        w_item.eligible        = i_is_tcp && (i_dest_port == HTTP_PORT);
        n_rd  = pop  ? ~r_rd : r_rd;
        n_wr  = push ? ~r_wr : r_wr;
        n_cnt = r_cnt + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wr] <= w_item;
        end
        if (!i_rst_n) begin
            r_rd  <= 1'b0;
            r_wr  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            r_rd  <= n_rd;
            r_wr  <= n_wr;
            r_cnt <= n_cnt;
        end
    end
endmodule
`default_nettype wire

FILE: rtl/hhpm_back.sv
// parse and match stage: keyword trackers, host capture window, verdict register
`default_nettype none
module hhpm_back
    import hhpm_pkg::*;
#(
    parameter int PATTERN_MAX = 32,
    parameter int HOST_MAX    = 66
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire t_item       i_item,
    input  wire logic [255:0] i_pattern,
    input  wire logic [5:0]  i_pattern_length,
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic             o_matched,
    output logic             o_request_seen,
    output logic             o_host_seen
);
    localparam int HCW = $clog2(HOST_MAX + 1);
    localparam int PLW = $clog2(PATTERN_MAX + 1);
    localparam int XW  = (PLW > 6) ? PLW : 6;

    logic            r_elig, n_elig;
    logic            r_ended, n_ended;
    logic [1:0]      r_get, n_get;
    logic [2:0]      r_post, n_post;
    logic            r_req, n_req;
    logic [2:0]      r_kw, n_kw;
    t_host_phase     r_phase, n_phase;
    logic [1:0]      r_skip, n_skip;
    logic [HCW-1:0]  r_hcnt, n_hcnt;
    logic [7:0]      r_win [PATTERN_MAX];
    logic [7:0]      n_win [PATTERN_MAX];
    logic            r_hit, n_hit;
    logic            r_ovalid, n_ovalid;
    logic            r_m, r_rs, r_hs, n_m, n_rs, n_hs;

    logic            take;
    logic [7:0]      b;
    logic            eq;
    logic [XW-1:0]   plen;
    logic            all_pfx;
    logic [7:0]      pc;

    assign o_ready        = !r_ovalid || i_ready;
    assign take           = i_valid && o_ready;
    assign o_valid        = r_ovalid;
    assign o_matched      = r_m;
    assign o_request_seen = r_rs;
    assign o_host_seen    = r_hs;
    assign b              = i_item.payload_byte;
    assign plen           = XW'(i_pattern_length);

    always_comb begin
        n_elig = r_elig; n_ended = r_ended; n_get = r_get; n_post = r_post;
        n_req = r_req; n_kw = r_kw; n_phase = r_phase; n_skip = r_skip;
        n_hcnt = r_hcnt; n_win = r_win; n_hit = r_hit;
        n_ovalid = r_ovalid && !i_ready;
        n_m = r_m; n_rs = r_rs; n_hs = r_hs;
        eq = 1'b1;
        pc = 8'd0;
        if (take) begin
            if (i_item.first_of_packet) begin
                n_elig = i_item.eligible; n_ended = 1'b0; n_get = '0; n_post = '0;
                n_req = 1'b0; n_kw = '0; n_phase = PH_SEARCH; n_skip = '0;
                n_hcnt = '0; n_hit = 1'b0;
                for (int k = 0; k < PATTERN_MAX; k++) n_win[k] = 8'd0;
            end
            if (i_item.byte_valid && !n_ended) begin
                if (b == CH_NUL) begin
                    n_ended = 1'b1;
                    if (n_phase != PH_SEARCH) n_phase = PH_DONE;
                end else begin
                    if (!n_req) begin
                        if (n_get == 2'd0 && b == "G") n_get = 2'd1;
                        else if (n_get == 2'd1 && b == "E") n_get = 2'd2;
                        else if (n_get == 2'd2 && b == "T") n_get = 2'd3;
                        else n_get = (b == "G") ? 2'd1 : 2'd0;
                        if (n_post == 3'd0 && b == "P") n_post = 3'd1;
                        else if (n_post == 3'd1 && b == "O") n_post = 3'd2;
                        else if (n_post == 3'd2 && b == "S") n_post = 3'd3;
                        else if (n_post == 3'd3 && b == "T") n_post = 3'd4;
                        else n_post = (b == "P") ? 3'd1 : 3'd0;
                        if (n_get == 2'd3 || n_post == 3'd4) n_req = 1'b1;
                    end
                    case (n_phase)
                        PH_SEARCH: begin
                            if (n_kw == 3'd0 && b == "H") n_kw = 3'd1;
                            else if (n_kw == 3'd1 && b == "o") n_kw = 3'd2;
                            else if (n_kw == 3'd2 && b == "s") n_kw = 3'd3;
                            else if (n_kw == 3'd3 && b == "t") n_kw = 3'd4;
                            else n_kw = (b == "H") ? 3'd1 : 3'd0;
                            if (n_kw == 3'd4) begin
                                n_phase = PH_SKIP;
                                n_skip  = 2'd0;
                            end
                        end
                        PH_SKIP: begin
                            n_skip = n_skip + 2'd1;
                            if (n_skip >= 2'd2) n_phase = PH_CAPTURE;
                        end
                        PH_CAPTURE: begin
                            if (b == CH_CR || b == CH_SPACE) begin
                                n_phase = PH_DONE;
                            end else begin
                                for (int k = PATTERN_MAX - 1; k > 0; k--)
                                    n_win[k] = n_win[k-1];
                                n_win[0] = b;
                                n_hcnt = n_hcnt + HCW'(1);
                                for (int k = 0; k < PATTERN_MAX; k++) begin
                                    if (XW'(k) < plen) begin
                                        pc = ((32'(plen) - 32'd1 - 32'(k)) < 32'd32)
                                            ? i_pattern[8*((32'(plen) - 32'd1 - 32'(k))
                                                % 32'd32) +: 8]
                                            : 8'd0;
                                        if (n_win[k] != pc) eq = 1'b0;
                                    end
                                end
                                if (plen != '0 && plen <= XW'(PATTERN_MAX)
                                    && 32'(n_hcnt) >= 32'(plen) && eq)
                                    n_hit = 1'b1;
                                if (32'(n_hcnt) >= HOST_MAX) n_phase = PH_DONE;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            if (i_item.last_of_packet) begin
                n_ovalid = 1'b1;
                n_rs = n_req;
                n_hs = (n_phase != PH_SEARCH);
                n_m  = n_elig && n_req && n_hs && (all_pfx || plen == '0 || n_hit);
            end
        end
    end

    assign all_pfx = (plen >= XW'(3)) && i_pattern[7:0] == "a"
                     && i_pattern[15:8] == "l" && i_pattern[23:16] == "l";

    always_ff @(posedge i_clk) begin
        r_m   <= n_m;
        r_rs  <= n_rs;
        r_hs  <= n_hs;
        if (!i_rst_n) begin
            r_elig <= 1'b0; r_ended <= 1'b0; r_get <= '0; r_post <= '0;
            r_req <= 1'b0; r_kw <= '0; r_phase <= PH_SEARCH; r_skip <= '0;
            r_hcnt <= '0; r_hit <= 1'b0; r_ovalid <= 1'b0;
            for (int k = 0; k < PATTERN_MAX; k++) r_win[k] <= 8'd0;
        end else begin
            r_elig <= n_elig; r_ended <= n_ended; r_get <= n_get; r_post <= n_post;
            r_req <= n_req; r_kw <= n_kw; r_phase <= n_phase; r_skip <= n_skip;
            r_hcnt <= n_hcnt; r_hit <= n_hit; r_ovalid <= n_ovalid;
            r_win <= n_win;
        end
    end
endmodule
`default_nettype wire

FILE: rtl/http_host_pattern_match_top.sv
// top level: configuration registers, input queue and match stage
// One payload byte is taken per cycle unless stalled; a verdict item follows the
// packet's last byte through a two-entry input queue and a registered result stage.
// One item per clock unless stalled; parse and window compare are combinational.
`default_nettype none
module http_host_pattern_match_top
    import hhpm_pkg::*;
#(
    parameter int PATTERN_MAX = 32,
    parameter int HOST_MAX    = 66
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [2:0]  i_cfg_index,
    input  wire logic [63:0] i_cfg_data,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic [7:0]  i_payload_byte,
    input  wire logic        i_byte_valid,
    input  wire logic        i_first_of_packet,
    input  wire logic        i_last_of_packet,
    input  wire logic [15:0] i_dest_port,
    input  wire logic        i_is_tcp,
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic             o_matched,
    output logic             o_request_seen,
    output logic             o_host_seen
);
    logic [255:0] r_pat;
    logic [5:0]   r_plen;
    logic         q_valid, q_ready;
    t_item        q_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pat  <= '0;
            r_plen <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_PAT0: r_pat[63:0]    <= i_cfg_data;
                REG_PAT1: r_pat[127:64]  <= i_cfg_data;
                REG_PAT2: r_pat[191:128] <= i_cfg_data;
                REG_PAT3: r_pat[255:192] <= i_cfg_data;
                REG_PLEN: r_plen         <= i_cfg_data[5:0];
                default: ;
            endcase
        end
    end

    hhpm_front u_front (
        .i_clk, .i_rst_n, .i_valid, .o_ready, .i_payload_byte, .i_byte_valid,
        .i_first_of_packet, .i_last_of_packet, .i_dest_port, .i_is_tcp,
        .o_valid(q_valid), .i_ready(q_ready), .o_item(q_item)
    );

    hhpm_back #(.PATTERN_MAX(PATTERN_MAX), .HOST_MAX(HOST_MAX)) u_back (
        .i_clk, .i_rst_n, .i_valid(q_valid), .o_ready(q_ready), .i_item(q_item),
        .i_pattern(r_pat), .i_pattern_length(r_plen), .o_valid, .i_ready,
        .o_matched, .o_request_seen, .o_host_seen
    );
endmodule
`default_nettype wire

FILE: test/tb_http_host_pattern_match_top.sv
// self-checking testbench for the http host pattern matcher top level
`timescale 1ns / 1ps
module tb_http_host_pattern_match_top;
    import hhpm_pkg::*;

    localparam int PAT_MAX  = 32;
    localparam int HOST_LIM = 66;
    localparam int CYCLE_LIMIT = 400000;

    typedef struct packed {
        logic matched;
        logic request_seen;
        logic host_seen;
    } t_verdict;

    typedef struct {
        logic [7:0]  b;
        logic        bv;
        logic        first;
        logic        last;
        logic [15:0] port;
        logic        tcp;
        logic        has_exp;
        t_verdict    exp;
    } t_row;

    logic        i_clk = 0;
    logic        i_rst_n = 0;
    logic        i_cfg_we = 0;
    logic [2:0]  i_cfg_index = '0;
    logic [63:0] i_cfg_data = '0;
    logic        i_valid = 0;
    logic        o_ready;
    logic [7:0]  i_payload_byte = '0;
    logic        i_byte_valid = 0;
    logic        i_first_of_packet = 0;
    logic        i_last_of_packet = 0;
    logic [15:0] i_dest_port = '0;
    logic        i_is_tcp = 0;
    logic        o_valid;
    logic        i_ready = 0;
    logic        o_matched;
    logic        o_request_seen;
    logic        o_host_seen;

    http_host_pattern_match_top dut (.*);

    always #5 i_clk = ~i_clk;

    // predictor state
    logic [63:0]  pat_reg [4];
    logic [5:0]   pat_len;
    logic         eligible, str_ended, req_found, hit;
    logic [1:0]   get_prog;
    logic [2:0]   post_prog, kw_prog;
    t_host_phase  phase;
    int unsigned  skip_cnt, host_cnt;
    logic [7:0]   window [PAT_MAX];

    t_verdict verdict_q [$];
    int errors = 0, mismatches = 0, verdicts = 0, match_cnt = 0;
    int cycles = 0;
    int send_idle = 0, recv_idle = 0;
    bit hold_recv = 0;

    function automatic logic [7:0] pchar(int i);
        if (i >= 32) return 8'h00;
        return pat_reg[i / 8][(i % 8) * 8 +: 8];
    endfunction

    function automatic logic [2:0] kw_step(logic [2:0] p, logic [7:0] b, string kw);
        if (p < kw.len() && b == kw[p]) return 3'(p + 3'd1);
        return (b == kw[0]) ? 3'd1 : 3'd0;
    endfunction

    function automatic void clear_parse();
        eligible = 0; str_ended = 0; req_found = 0; hit = 0;
        get_prog = 0; post_prog = 0; kw_prog = 0;
        phase = PH_SEARCH; skip_cnt = 0; host_cnt = 0;
        foreach (window[k]) window[k] = 8'h00;
    endfunction

    function automatic void capture(logic [7:0] b);
        bit eq;
        for (int k = PAT_MAX - 1; k > 0; k--) window[k] = window[k - 1];
        window[0] = b;
        host_cnt++;
        if (pat_len > 0 && pat_len <= PAT_MAX && host_cnt >= pat_len) begin
            eq = 1;
            for (int k = 0; k < pat_len; k++)
                if (window[k] != pchar(pat_len - 1 - k)) eq = 0;
            if (eq) hit = 1;
        end
        if (host_cnt >= HOST_LIM) phase = PH_DONE;
    endfunction

    function automatic void parse_byte(logic [7:0] b);
        if (str_ended) return;
        if (b == CH_NUL) begin
            str_ended = 1;
            if (phase != PH_SEARCH) phase = PH_DONE;
            return;
        end
        if (!req_found) begin
            get_prog = 2'(kw_step({1'b0, get_prog}, b, "GET"));
            post_prog = kw_step(post_prog, b, "POST");
            if (get_prog == 3 || post_prog == 4) req_found = 1;
        end
        case (phase)
            PH_SEARCH: begin
                kw_prog = kw_step(kw_prog, b, "Host");
                if (kw_prog == 4) begin
                    phase = PH_SKIP;
                    skip_cnt = 0;
                end
            end
            PH_SKIP: begin
                skip_cnt++;
                if (skip_cnt >= 2) phase = PH_CAPTURE;
            end
            PH_CAPTURE: begin
                if (b == CH_CR || b == CH_SPACE) phase = PH_DONE;
                else capture(b);
            end
            default: ;
        endcase
    endfunction

    function automatic bit predict_item(t_row r, output t_verdict v);
        bit all_pre;
        if (r.first) begin
            clear_parse();
            eligible = r.tcp && r.port == HTTP_PORT;
        end
        if (r.bv) parse_byte(r.b);
        if (!r.last) return 0;
        all_pre = pat_len >= 3 && pchar(0) == "a" && pchar(1) == "l" && pchar(2) == "l";
        v.request_seen = req_found;
        v.host_seen = phase != PH_SEARCH;
        v.matched = eligible && req_found && v.host_seen && (all_pre || pat_len == 0 || hit);
        return 1;
    endfunction

    task automatic cfg_write(logic [2:0] idx, logic [63:0] val);
        @(negedge i_clk);
        i_cfg_we <= 1; i_cfg_index <= idx; i_cfg_data <= val;
        @(negedge i_clk);
        i_cfg_we <= 0;
        if (idx == REG_PLEN) pat_len = val[5:0];
        else pat_reg[idx[1:0]] = val;
    endtask

    task automatic set_pattern(string s, int len);
        logic [63:0] w [4];
        foreach (w[j]) w[j] = '0;
        for (int k = 0; k < s.len() && k < 32; k++) w[k / 8][(k % 8) * 8 +: 8] = s[k];
        cfg_write(REG_PAT0, w[0]);
        cfg_write(REG_PAT1, w[1]);
        cfg_write(REG_PAT2, w[2]);
        cfg_write(REG_PAT3, w[3]);
        cfg_write(REG_PLEN, 64'(len[5:0]));
    endtask

    task automatic wait_drain();
        i_valid <= 0;
        while (verdict_q.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    // drive one item, hold until accepted
    task automatic send_item(t_row r);
        t_verdict v;
        if (send_idle != 0 && $urandom_range(99) < send_idle) begin
            i_valid <= 0;
            @(negedge i_clk);
            while (send_idle != 0 && $urandom_range(99) < send_idle) @(negedge i_clk);
        end
        i_valid <= 1;
        i_payload_byte <= r.b; i_byte_valid <= r.bv;
        i_first_of_packet <= r.first; i_last_of_packet <= r.last;
        i_dest_port <= r.port; i_is_tcp <= r.tcp;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        if (predict_item(r, v)) begin
            if (r.has_exp && v != r.exp) begin
                errors++;
                $display("predictor disagrees with table row: %b vs %b", v, r.exp);
            end
            verdict_q.push_back(v);
        end
        @(negedge i_clk);
    endtask

    function automatic t_row mk(logic [7:0] b, logic bv, logic f, logic l,
                                logic [15:0] p, logic t);
        t_row r;
        r.b = b; r.bv = bv; r.first = f; r.last = l; r.port = p; r.tcp = t;
        r.has_exp = 0; r.exp = '0;
        return r;
    endfunction

    task automatic send_text(string s, logic [15:0] port, logic tcp, bit close);
        for (int k = 0; k < s.len(); k++)
            send_item(mk(s[k], 1, k == 0, close && k == s.len() - 1, port, tcp));
    endtask

    function automatic string rand_host();
        string h = "";
        string al = "abcdefgxyz.-0123456789";
        int n = $urandom_range(100) < 10 ? $urandom_range(60, 80) : $urandom_range(1, 20);
        for (int k = 0; k < n; k++) h = {h, string'(al[$urandom_range(al.len() - 1)])};
        return h;
    endfunction

    task automatic random_packet();
        string s, h, req;
        int kind = $urandom_range(99);
        logic [15:0] port = $urandom_range(99) < 80 ? HTTP_PORT : 16'($urandom);
        logic tcp = $urandom_range(99) < 90;
        if (kind < 70) begin
            h = rand_host();
            req = $urandom_range(1) ? "GET /" : "POST /";
            s = {req, " HTTP/1.1\r\nHost: ", h};
            case ($urandom_range(3))
                0: s = {s, "\r\nX"};
                1: s = {s, " a"};
                2: s = {s, string'(8'h0), "z"};
                default: ;
            endcase
        end else if (kind < 85) begin
            s = "";
            for (int k = 0; k < $urandom_range(1, 12); k++)
                s = {s, string'(8'($urandom_range(1, 255)))};
            s = {s, "GEHost", string'(8'h0), "xabc"};
        end else begin
            s = "";
            for (int k = 0; k < $urandom_range(1, 16); k++) begin
                byte c = $urandom;
                if (c == 0) c = 8'hff;
                s = {s, string'(c)};
            end
        end
        for (int k = 0; k < s.len(); k++) begin
            t_row r = mk(s[k], 1, k == 0, k == s.len() - 1, port, tcp);
            if (r.first) begin
                r.b = 8'($urandom); r.bv = $urandom_range(9) != 0;
                if (r.b == 8'h00 && $urandom_range(3) != 0) r.b = s[k];
            end else if ($urandom_range(30) == 0) r.bv = 0;
            send_item(r);
        end
        // noise last item with random byte, byte valid, port and tcp
        if ($urandom_range(9) == 0)
            send_item(mk(8'($urandom), 1'($urandom), 0, 1, 16'($urandom), 1'($urandom)));
    endtask

    // receiver side: ready pattern and checking
    always @(negedge i_clk) begin
        if (!i_rst_n) i_ready <= 0;
        else if (hold_recv) i_ready <= 0;
        else i_ready <= !(recv_idle != 0 && $urandom_range(99) < recv_idle);
    end

    always @(posedge i_clk) begin
        t_verdict got, want;
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("tb_http_host_pattern_match_top failed");
            $finish;
        end
        if (i_rst_n && o_valid && i_ready) begin
            got = '{o_matched, o_request_seen, o_host_seen};
            if (verdict_q.size() == 0) begin
                errors++;
                if (mismatches++ < 10) $display("unexpected verdict %b", got);
            end else begin
                want = verdict_q.pop_front();
                verdicts++;
                if (got.matched) match_cnt++;
                if (got != want) begin
                    errors++;
                    if (mismatches++ < 10)
                        $display("verdict mismatch: exp m=%b r=%b h=%b got m=%b r=%b h=%b",
                                 want.matched, want.request_seen, want.host_seen,
                                 got.matched, got.request_seen, got.host_seen);
                end
            end
        end
    end

    t_row dir [$];

    initial begin
        t_row r;
        foreach (pat_reg[k]) pat_reg[k] = '0;
        pat_len = 0;
        clear_parse();
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1;

        // directed rows: empty pattern, extremes, single-item packets
        r = mk(8'h00, 0, 1, 1, 16'd80, 1); r.has_exp = 1; r.exp = 3'b000; dir.push_back(r);
        r = mk(8'hff, 1, 1, 1, 16'hffff, 0); r.has_exp = 1; r.exp = 3'b000; dir.push_back(r);
        r = mk(8'h00, 1, 0, 1, 16'd0, 1); r.has_exp = 1; r.exp = 3'b000; dir.push_back(r);
        foreach (dir[k]) send_item(dir[k]);
        // missing first flag continues packet
        send_item(mk("G", 1, 1, 0, 16'd80, 1));
        send_item(mk("E", 1, 0, 0, 16'd0, 0));
        send_item(mk("T", 1, 0, 1, 16'd0, 0));
        send_item(mk("H", 1, 0, 0, 16'd0, 0));
        send_text("PHostXYab", 16'd80, 1, 1);
        send_text("POST Host", 16'd80, 1, 1);
        send_text("GET Ho", 16'd80, 1, 0);
        send_item(mk(8'h00, 1, 0, 0, 16'd0, 1));
        send_item(mk("s", 1, 0, 1, 16'd0, 1));
        send_text("GETHost\r\n", 16'd81, 1, 1);
        wait_drain();

        set_pattern("all", 3);
        send_text("GET Host: zz", 16'd80, 1, 1);
        wait_drain();
        set_pattern("al", 2);
        send_text("GET Host: xaly", 16'd80, 1, 1);
        wait_drain();
        set_pattern({"abcdefgh", "ijklmnop", "qrstuvwx", "yz012345"}, 32);
        send_text({"GET Host: -", "abcdefghijklmnopqrstuvwxyz012345", "\r"}, 16'd80, 1, 1);
        wait_drain();
        set_pattern({"abcdefgh", "ijklmnop", "qrstuvwx", "yz012345"}, 63);
        send_text("GET Host: abc", 16'd80, 1, 1);
        wait_drain();

        for (int ph = 0; ph < 3; ph++) begin
            send_idle = ph == 0 ? 22 : (ph == 1 ? 85 : 0);
            recv_idle = ph == 0 ? 85 : (ph == 1 ? 22 : 0);
            for (int p = 0; p < 5; p++) begin
                case ($urandom_range(4))
                    0: set_pattern("", 0);
                    1: set_pattern("all", $urandom_range(3, 40));
                    2: set_pattern("xyz", 3);
                    3: set_pattern({"abcdefgh", "ijklmnop", "qrstuvwx", "yz012345"}, 63);
                    default: begin
                        string h = rand_host();
                        int a = $urandom_range(h.len() - 1);
                        int l = $urandom_range(1, h.len() - a);
                        set_pattern(h.substr(a, a + l - 1), l);
                        for (int k = 0; k < 4; k++)
                            if ($urandom_range(3) == 0) cfg_write(3'(k), {$urandom, $urandom});
                    end
                endcase
                for (int q = 0; q < 2; q++) random_packet();
                if (p == 2) begin
                    fork
                        begin
                            hold_recv = 1;
                            repeat (60) @(posedge i_clk);
                            hold_recv = 0;
                        end
                        begin
                            random_packet();
                            random_packet();
                        end
                    join
                end
                wait_drain();
            end
        end
        wait_drain();
        repeat (20) @(posedge i_clk);
        $display("checked %0d verdicts (%0d matches) over several pattern settings",
                 verdicts, match_cnt);
        if (errors == 0 && verdict_q.size() == 0) begin
            $display("tb_http_host_pattern_match_top passed");
        end else begin
            $display("mismatches: %0d, left over: %0d", errors, verdict_q.size());
            $display("tb_http_host_pattern_match_top failed");
        end
        $finish;
    end
endmodule
